// ----- hw/rtl/tcpwm_pkg.sv -----
// Package for the two-channel PWM generator.
// Holds register offsets, control bit positions, operation codes and size defaults.
// Used by two_channel_pwm_generator; has no dependencies.
package tcpwm_pkg;

  localparam int NUM_CHANNELS_DEF = 2;
  localparam int COUNT_WIDTH_DEF  = 32;
  localparam int MAX_CHANNELS     = 2;

  localparam int OP_WIDTH        = 2;
  localparam int OFFSET_WIDTH    = 8;
  localparam int VALUE_WIDTH     = 32;
  localparam int CTL_WIDTH       = 16;
  localparam int CHAN_CTL_STRIDE = 8;

  localparam int IN_DATA_WIDTH  = 40;
  localparam int OUT_DATA_WIDTH = 40;

  localparam logic [OFFSET_WIDTH-1:0] OFF_CTL = 8'h00;
  localparam logic [OFFSET_WIDTH-1:0] OFF_RNG [MAX_CHANNELS] = '{8'h10, 8'h20};
  localparam logic [OFFSET_WIDTH-1:0] OFF_DAT [MAX_CHANNELS] = '{8'h14, 8'h24};

  localparam int CTL_EN_BIT   = 0;
  localparam int CTL_SBIT_BIT = 3;
  localparam int CTL_POLA_BIT = 4;

  localparam logic [7:0] RANGE_RESET = 8'h20;

  typedef enum logic [OP_WIDTH-1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } op_t;

endpackage

// ----- hw/rtl/two_channel_pwm_generator.sv -----
// Top level of the two-channel PWM generator: register file, period counters and result stage.
// Depends on tcpwm_pkg for offsets, control bit positions and operation codes.
//
//   channel  | tvalid/tready      | tdata (low bit up)                         | tuser
//   ---------+--------------------+--------------------------------------------+--------
//   s        | s_tvalid/s_tready  | reg_offset[7:0], write_value[39:8]         | op[1:0]
//   m        | m_tvalid/m_tready  | read_value[31:0], level_ch1[32], level_ch2[33] | none
//
// The register file and counters update at the accepting edge and the result register loads
// in the same edge, so results appear in the following cycle.
// A new transaction is accepted every cycle while the result register is empty or being drained.
// The synchronous reset clears the control word, counters and data words, sets each range to 0x20
// and empties the result register. A stalled result holds s_tready low until it is taken.
module two_channel_pwm_generator #(
  parameter int NUM_CHANNELS = tcpwm_pkg::NUM_CHANNELS_DEF,
  parameter int COUNT_WIDTH  = tcpwm_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // reg_offset [7:0], write_value [39:8]
  input  logic [tcpwm_pkg::IN_DATA_WIDTH-1:0]    s_tdata,
  // op [1:0]
  input  logic [tcpwm_pkg::OP_WIDTH-1:0]         s_tuser,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // read_value [31:0], level_ch1 [32], level_ch2 [33], zero [39:34]
  output logic [tcpwm_pkg::OUT_DATA_WIDTH-1:0]   m_tdata
);

  localparam int MAXC = tcpwm_pkg::MAX_CHANNELS;

  logic                                  accept;
  tcpwm_pkg::op_t                        op;
  logic [tcpwm_pkg::OFFSET_WIDTH-1:0]    reg_offset;
  logic [tcpwm_pkg::VALUE_WIDTH-1:0]     write_value;

  logic [tcpwm_pkg::CTL_WIDTH-1:0]       control;
  logic [tcpwm_pkg::CTL_WIDTH-1:0]       control_next;
  logic [COUNT_WIDTH-1:0]                range_word [MAXC];
  logic [COUNT_WIDTH-1:0]                range_word_next [MAXC];
  logic [COUNT_WIDTH-1:0]                data_word [MAXC];
  logic [COUNT_WIDTH-1:0]                data_word_next [MAXC];
  logic [COUNT_WIDTH-1:0]                period_count [MAXC];
  logic [COUNT_WIDTH-1:0]                period_count_next [MAXC];
  logic [COUNT_WIDTH-1:0]                range_last [MAXC];
  logic [7:0]                            chan_ctl [MAXC];
  logic [MAXC-1:0]                       level_next;
  logic [tcpwm_pkg::VALUE_WIDTH-1:0]     read_value_next;

  logic [tcpwm_pkg::VALUE_WIDTH-1:0]     read_value;
  logic [MAXC-1:0]                       level;

  assign s_tready    = !m_tvalid || m_tready;
  assign accept      = s_tvalid && s_tready;
  assign op          = tcpwm_pkg::op_t'(s_tuser);
  assign reg_offset  = s_tdata[tcpwm_pkg::OFFSET_WIDTH-1:0];
  assign write_value = s_tdata[tcpwm_pkg::OFFSET_WIDTH +: tcpwm_pkg::VALUE_WIDTH];

  always_comb begin
    control_next = control;
    if (op == tcpwm_pkg::OP_WRITE && reg_offset == tcpwm_pkg::OFF_CTL) begin
      control_next = write_value[tcpwm_pkg::CTL_WIDTH-1:0];
    end
  end

  always_comb begin
    for (int c = 0; c < MAXC; c++) begin
      range_word_next[c]   = range_word[c];
      data_word_next[c]    = data_word[c];
      period_count_next[c] = period_count[c];
      chan_ctl[c]          = control_next[tcpwm_pkg::CHAN_CTL_STRIDE*c +: 8];
      range_last[c]        = (range_word[c] == '0) ? '0 : range_word[c] - 1'b1;
      level_next[c]        = 1'b0;
      if (c < NUM_CHANNELS) begin
        case (op)
          tcpwm_pkg::OP_TICK: begin
            if (!control[tcpwm_pkg::CHAN_CTL_STRIDE*c + tcpwm_pkg::CTL_EN_BIT]) begin
              period_count_next[c] = '0;
            end else if (period_count[c] >= range_last[c]) begin
              period_count_next[c] = '0;
            end else begin
              period_count_next[c] = period_count[c] + 1'b1;
            end
          end
          tcpwm_pkg::OP_WRITE: begin
            if (reg_offset == tcpwm_pkg::OFF_RNG[c]) begin
              range_word_next[c] = write_value[COUNT_WIDTH-1:0];
            end
            if (reg_offset == tcpwm_pkg::OFF_DAT[c]) begin
              data_word_next[c] = write_value[COUNT_WIDTH-1:0];
            end
          end
          default: begin
          end
        endcase
        if (!chan_ctl[c][tcpwm_pkg::CTL_EN_BIT]) begin
          level_next[c] = chan_ctl[c][tcpwm_pkg::CTL_SBIT_BIT];
        end else begin
          level_next[c] = (period_count_next[c] < data_word_next[c])
                          ^ chan_ctl[c][tcpwm_pkg::CTL_POLA_BIT];
        end
      end
    end
  end

  always_comb begin
    read_value_next = '0;
    if (op == tcpwm_pkg::OP_READ) begin
      if (reg_offset == tcpwm_pkg::OFF_CTL) begin
        read_value_next = tcpwm_pkg::VALUE_WIDTH'(control);
      end
      for (int c = 0; c < MAXC; c++) begin
        if (c < NUM_CHANNELS) begin
          if (reg_offset == tcpwm_pkg::OFF_RNG[c]) begin
            read_value_next = tcpwm_pkg::VALUE_WIDTH'(range_word[c]);
          end
          if (reg_offset == tcpwm_pkg::OFF_DAT[c]) begin
            read_value_next = tcpwm_pkg::VALUE_WIDTH'(data_word[c]);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      control <= '0;
      for (int c = 0; c < MAXC; c++) begin
        range_word[c]   <= COUNT_WIDTH'(tcpwm_pkg::RANGE_RESET);
        data_word[c]    <= '0;
        period_count[c] <= '0;
      end
    end else if (accept) begin
      control <= control_next;
      for (int c = 0; c < MAXC; c++) begin
        range_word[c]   <= range_word_next[c];
        data_word[c]    <= data_word_next[c];
        period_count[c] <= period_count_next[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      read_value <= read_value_next;
      level      <= level_next;
    end
  end

  assign m_tdata = {6'b0, level, read_value};

endmodule
